@@ hw/rtl/dual_button_debounce_autorepeat_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual button debounce block
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define DUAL_BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication.
`define DBAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DBAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dbar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbar_pkg
// Types, widths and register codes for the dual button debounce block.
// ----------------------------------------------------------------------------
package dbar_pkg;

  // Tick counter width and configuration register width
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int IDX_W      = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_FILTER = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_HOLD   = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_REPEAT = IDX_W'(2);

  // Register values after reset
  localparam logic [CFG_W-1:0] FILTER_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] HOLD_RST   = CFG_W'(1000);
  localparam logic [CFG_W-1:0] REPEAT_RST = CFG_W'(200);

  // Per-button phase
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_FILTER   = 2'd1,
    PH_HOLD     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_t;

  // Thresholds handed to each button channel
  typedef struct packed {
    logic [CFG_W-1:0] filter_ticks;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] repeat_ticks;
  } dbar_cfg_t;

  // Compare a counter against a full register value
  function automatic logic count_hit(input logic [COUNT_BITS-1:0] cnt,
                                     input logic [CFG_W-1:0] thr);
    count_hit = (CMP_W'(cnt) == CMP_W'(thr));
  endfunction

endpackage

@@ hw/rtl/dbar_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbar_channel
// One button: phase machine and tick counter, pulse read on the stepping beat (not gated by step).
// ----------------------------------------------------------------------------
module dbar_channel import dbar_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,     // a tick is accepted this cycle
  input  logic      active,   // button level for that tick
  input  dbar_cfg_t cfg,
  output logic      pulse     // press or repeat pulse for that tick
);

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  hit;

  assign count_inc = count_r + COUNT_BITS'(1);

  // Pick the threshold of the current phase
  always_comb begin
    case (phase_r)
      PH_FILTER: hit = count_hit(count_inc, cfg.filter_ticks);
      PH_HOLD:   hit = count_hit(count_inc, cfg.hold_ticks);
      PH_REPEAT: hit = count_hit(count_inc, cfg.repeat_ticks);
      default:   hit = 1'b0;
    endcase
  end

  // Next phase and counter
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (step) begin
      if (!active) begin
        phase_nxt = PH_RELEASED;
        count_nxt = '0;
      end else begin
        count_nxt = hit ? '0 : count_inc;
        case (phase_r)
          PH_RELEASED: phase_nxt = PH_FILTER;
          PH_FILTER:   phase_nxt = hit ? PH_HOLD : PH_FILTER;
          PH_HOLD:     phase_nxt = hit ? PH_REPEAT : PH_HOLD;
          default:     phase_nxt = PH_REPEAT;
        endcase
      end
    end
  end

  // Pulse when the active tick reaches the phase threshold
  always_comb begin
    pulse = active && hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/dual_button_debounce_autorepeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_button_debounce_autorepeat
// Debounce two buttons on a millisecond tick stream, with hold and auto-repeat.
//
//   channel  dir   handshake             payload
//   in_      in    in_tvalid/in_tready   tdata: button_a_active, button_b_active
//   out_     out   out_tvalid/out_tready tdata: press_a, press_b
//   cfg_     in    cfg_valid/cfg_ready   cfg_index, cfg_data (16 bits)
//
// One tick per cycle while in_tready is high; its result goes to the output or skid register.
// Phase and counter update in the accept cycle; the pulse is registered.
// A two-entry output buffer lets one more tick in while a result is stalled.
// rst_n is synchronous: phases released, counters zero, registers at defaults.
// ----------------------------------------------------------------------------
`include "dual_button_debounce_autorepeat_defines.svh"

module dual_button_debounce_autorepeat import dbar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [0] button_a_active, [1] button_b_active
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [0] press_a, [1] press_b
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  dbar_cfg_t  cfg_r;
  logic       in_beat, out_beat;
  logic       pulse_a, pulse_b;
  logic [1:0] out_data_r, skid_data_r;
  logic       out_valid_r, skid_valid_r;

  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_ticks <= FILTER_RST;
      cfg_r.hold_ticks   <= HOLD_RST;
      cfg_r.repeat_ticks <= REPEAT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER: cfg_r.filter_ticks <= cfg_data;
        CFG_HOLD:   cfg_r.hold_ticks   <= cfg_data;
        CFG_REPEAT: cfg_r.repeat_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Button channels
  dbar_channel u_chan_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_beat),
    .active (in_tdata[0]),
    .cfg    (cfg_r),
    .pulse  (pulse_a)
  );

  dbar_channel u_chan_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_beat),
    .active (in_tdata[1]),
    .cfg    (cfg_r),
    .pulse  (pulse_b)
  );

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_beat) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_beat) begin
      if (!out_valid_r || out_beat) begin
        out_data_r  <= {pulse_b, pulse_a};
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= {pulse_b, pulse_a};
        skid_valid_r <= 1'b1;
      end
    end else if (out_beat) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // Checks
  `DBAR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds data with empty output")
  `DBAR_ASSERT_NEXT(a_skid_drains, out_beat && skid_valid_r, out_valid_r && !skid_valid_r, "skid beat lost")
  `DBAR_ASSERT_NOW(a_pulse_needs_press, !in_tdata[0] || !in_tdata[1], !(pulse_a && !in_tdata[0]) && !(pulse_b && !in_tdata[1]), "pulse on released button")

endmodule
